// ===== sv/ecomp_pkg.sv =====
// Package with shared types and constants of the environment sensor compensation block.
package ecomp_pkg;

  // Operation codes of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  // Control word that the sequencer hands to the arithmetic unit.
  typedef struct packed {
    alu_op_e    op;
    logic [4:0] sh;
    logic       lsr;
  } alu_ctl_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TEMP   = 3'd0;
  localparam logic [2:0] CFG_PLOW   = 3'd1;
  localparam logic [2:0] CFG_PHIGH  = 3'd2;
  localparam logic [2:0] CFG_PNINE  = 3'd3;
  localparam logic [2:0] CFG_HUM    = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Raw codes that mark a skipped channel.
  localparam logic [23:0] RAW_SKIP_24 = 24'h800000;
  localparam logic [15:0] RAW_SKIP_16 = 16'h8000;

endpackage

// ===== sv/ecomp_if.sv =====
// Handshake interfaces for the raw reading channel and the compensated result channel.
interface ecomp_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] temp_raw;
  logic [23:0] press_raw;
  logic [15:0] hum_raw;

  modport source (output valid, temp_raw, press_raw, hum_raw, input ready);
  modport sink   (input valid, temp_raw, press_raw, hum_raw, output ready);
endinterface

interface ecomp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic        [31:0] pressure;
  logic        [16:0] humidity;

  modport source (output valid, temperature, pressure, humidity, input ready);
  modport sink   (input valid, temperature, pressure, humidity, output ready);
endinterface

// ===== sv/ecomp_alu.sv =====
// Shared 32-bit add, subtract and multiply unit with a trailing right shift.
module ecomp_alu import ecomp_pkg::*; (
  input  alu_ctl_t    ctl_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  logic signed [63:0] prod;
  logic        [31:0] pre;

  // Operation on a wrapping 32-bit datapath.
  always_comb begin
    prod = $signed(a_i) * $signed(b_i);
    case (ctl_i.op)
      ALU_ADD: pre = a_i + b_i;
      ALU_SUB: pre = a_i - b_i;
      ALU_MUL: pre = prod[31:0];
      default: pre = a_i;
    endcase
  end

  // Logical or arithmetic right shift of the wrapped value.
  assign y_o = ctl_i.lsr ? (pre >> ctl_i.sh) : 32'($signed(pre) >>> ctl_i.sh);

endmodule

// ===== sv/ecomp_div.sv =====
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
module ecomp_div import ecomp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o,
  output logic        done_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [32:0] shifted;
  logic [32:0] diff;

  // One shift and trial subtraction.
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = shifted - {1'b0, dvs_q};
    if (!diff[32]) begin
      rem_d = diff[31:0];
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = shifted[31:0];
      quo_d = {quo_q[30:0], 1'b0};
    end
  end

  // Iteration counter and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 6'd32;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== sv/environment_sensor_compensation.sv =====
// Top level: sequencer, scratch registers and coefficients of the sensor compensation.
//
//   channel   direction  handshake        beat content
//   in_i      sink       valid / ready    temp_raw, press_raw, hum_raw
//   out_o     source     valid / ready    temperature, pressure, humidity
//   cfg       write      cfg_we_i         cfg_idx_i, cfg_data_i
//
// One beat with all channels runs through 7 temperature steps, 18 pressure steps, one
// divider start, the 32-step bit-serial divider, 7 pressure post steps, 18 humidity steps,
// the output state and the idle state. A zero pressure divisor skips the divider and the
// post steps, and a skipped pressure skips all pressure work; a skipped temperature or
// humidity skips its own steps.
// Reset clears the coefficients, the fine temperature and all control state.
// Input is taken only while the sequencer is idle; a finished result waits in the output
// register while the next beat is accepted, and the sequencer stalls only if that is still full.
module environment_sensor_compensation import ecomp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ecomp_in_if.sink            in_i,
  ecomp_out_if.source         out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEMP,
    ST_PRESS,
    ST_DIVGO,
    ST_DIV,
    ST_POST,
    ST_HUM,
    ST_DONE
  } state_e;

  localparam logic [2:0] R0 = 3'd0;
  localparam logic [2:0] R1 = 3'd1;
  localparam logic [2:0] R2 = 3'd2;
  localparam logic [2:0] R3 = 3'd3;
  localparam logic [2:0] R4 = 3'd4;
  localparam logic [2:0] R5 = 3'd5;

  localparam logic [4:0] TEMP_LAST  = 5'd6;
  localparam logic [4:0] PRESS_LAST = 5'd17;
  localparam logic [4:0] POST_LAST  = 5'd6;
  localparam logic [4:0] HUM_LAST   = 5'd17;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  // Coefficient registers.
  logic [47:0] tc_q;
  logic [63:0] pl_q;
  logic [63:0] ph_q;
  logic [15:0] p9_q;
  logic [63:0] hc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pl_q <= '0;
      ph_q <= '0;
      p9_q <= '0;
      hc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP:  tc_q <= cfg_data_i[47:0];
        CFG_PLOW:  pl_q <= cfg_data_i;
        CFG_PHIGH: ph_q <= cfg_data_i;
        CFG_PNINE: p9_q <= cfg_data_i[15:0];
        CFG_HUM:   hc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e             state_q;
  logic [4:0]         step_q;
  logic [23:0]        traw_q;
  logic [23:0]        praw_q;
  logic [15:0]        hraw_q;
  logic [31:0]        r_q [6];
  logic [31:0]        fine_q;
  logic signed [15:0] temp_res_q;
  logic [31:0]        press_res_q;
  logic [16:0]        hum_res_q;
  logic               out_vld_q;
  logic signed [15:0] out_temp_q;
  logic [31:0]        out_press_q;
  logic [16:0]        out_hum_q;

  // Coefficient fields.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4s, h5, h6;
  logic [31:0] padc;

  assign t1  = {16'b0, tc_q[15:0]};
  assign t2  = sx16(tc_q[31:16]);
  assign t3  = sx16(tc_q[47:32]);
  assign p1  = {16'b0, pl_q[15:0]};
  assign p2  = sx16(pl_q[31:16]);
  assign p3  = sx16(pl_q[47:32]);
  assign p4  = {pl_q[63:48], 16'b0};
  assign p5  = sx16(ph_q[15:0]);
  assign p6  = sx16(ph_q[31:16]);
  assign p7  = sx16(ph_q[47:32]);
  assign p8  = sx16(ph_q[63:48]);
  assign p9  = sx16(p9_q);
  assign h1  = {24'b0, hc_q[7:0]};
  assign h2  = sx16(hc_q[23:8]);
  assign h3  = {24'b0, hc_q[31:24]};
  assign h4s = {hc_q[43:32], 20'b0};
  assign h5  = sx12(hc_q[55:44]);
  assign h6  = sx8(hc_q[63:56]);
  assign padc = {12'b0, praw_q[23:4]};

  // Microcode: operands, operation and destination of each step.
  alu_ctl_t    ctl;
  logic [31:0] opa, opb, alu_y;
  logic [2:0]  dst;
  logic        wr, wr_fine;

  always_comb begin
    ctl     = '{op: ALU_ADD, sh: 5'd0, lsr: 1'b0};
    opa     = '0;
    opb     = '0;
    dst     = R0;
    wr      = 1'b0;
    wr_fine = 1'b0;
    case (state_q)
      ST_TEMP: begin
        wr = 1'b1;
        case (step_q)
          5'd0: begin opa = {15'b0, traw_q[23:7]}; opb = {t1[30:0], 1'b0};
            ctl.op = ALU_SUB; dst = R0; end
          5'd1: begin opa = r_q[0]; opb = t2; ctl.op = ALU_MUL; ctl.sh = 5'd11; dst = R0; end
          5'd2: begin opa = {16'b0, traw_q[23:8]}; opb = t1; ctl.op = ALU_SUB; dst = R1; end
          5'd3: begin opa = r_q[1]; opb = r_q[1]; ctl.op = ALU_MUL; ctl.sh = 5'd12; dst = R1; end
          5'd4: begin opa = r_q[1]; opb = t3; ctl.op = ALU_MUL; ctl.sh = 5'd14; dst = R1; end
          5'd5: begin opa = r_q[0]; opb = r_q[1]; wr = 1'b0; wr_fine = 1'b1; end
          default: wr = 1'b0;
        endcase
      end
      ST_PRESS: begin
        wr = 1'b1;
        case (step_q)
          5'd0: begin opa = {fine_q[31], fine_q[31:1]}; opb = 32'd64000; ctl.op = ALU_SUB;
            dst = R0; end
          5'd1: begin opa = r_q[0]; ctl.sh = 5'd2; dst = R1; end
          5'd2: begin opa = r_q[1]; opb = r_q[1]; ctl.op = ALU_MUL; ctl.sh = 5'd11; dst = R2; end
          5'd3: begin opa = r_q[2]; opb = p6; ctl.op = ALU_MUL; dst = R2; end
          5'd4: begin opa = r_q[0]; opb = p5; ctl.op = ALU_MUL; dst = R3; end
          5'd5: begin opa = r_q[2]; opb = {r_q[3][30:0], 1'b0}; dst = R2; end
          5'd6: begin opa = r_q[2]; ctl.sh = 5'd2; dst = R2; end
          5'd7: begin opa = r_q[2]; opb = p4; dst = R2; end
          5'd8: begin opa = r_q[1]; opb = r_q[1]; ctl.op = ALU_MUL; ctl.sh = 5'd13; dst = R3; end
          5'd9: begin opa = p3; opb = r_q[3]; ctl.op = ALU_MUL; ctl.sh = 5'd3; dst = R3; end
          5'd10: begin opa = p2; opb = r_q[0]; ctl.op = ALU_MUL; ctl.sh = 5'd1; dst = R4; end
          5'd11: begin opa = r_q[3]; opb = r_q[4]; ctl.sh = 5'd18; dst = R3; end
          5'd12: begin opa = r_q[3]; opb = 32'd32768; dst = R3; end
          5'd13: begin opa = r_q[3]; opb = p1; ctl.op = ALU_MUL; ctl.sh = 5'd15; dst = R3; end
          5'd14: begin opa = 32'd1048576; opb = padc; ctl.op = ALU_SUB; dst = R4; end
          5'd15: begin opa = r_q[2]; ctl.sh = 5'd12; dst = R5; end
          5'd16: begin opa = r_q[4]; opb = r_q[5]; ctl.op = ALU_SUB; dst = R4; end
          5'd17: begin opa = r_q[4]; opb = 32'd3125; ctl.op = ALU_MUL; dst = R4; end
          default: wr = 1'b0;
        endcase
      end
      ST_POST: begin
        wr = 1'b1;
        case (step_q)
          5'd0: begin opa = {3'b0, r_q[4][31:3]}; opb = {3'b0, r_q[4][31:3]};
            ctl.op = ALU_MUL; ctl.sh = 5'd13; ctl.lsr = 1'b1; dst = R5; end
          5'd1: begin opa = p9; opb = r_q[5]; ctl.op = ALU_MUL; ctl.sh = 5'd12; dst = R5; end
          5'd2: begin opa = {2'b0, r_q[4][31:2]}; opb = p8; ctl.op = ALU_MUL; ctl.sh = 5'd13;
            dst = R0; end
          5'd3: begin opa = r_q[5]; opb = r_q[0]; dst = R5; end
          5'd4: begin opa = r_q[5]; opb = p7; ctl.sh = 5'd4; dst = R5; end
          5'd5: begin opa = r_q[4]; opb = r_q[5]; dst = R5; end
          default: wr = 1'b0;
        endcase
      end
      ST_HUM: begin
        wr = 1'b1;
        case (step_q)
          5'd0: begin opa = fine_q; opb = 32'd76800; ctl.op = ALU_SUB; dst = R0; end
          5'd1: begin opa = {2'b0, hraw_q, 14'b0}; opb = h4s; ctl.op = ALU_SUB; dst = R1; end
          5'd2: begin opa = h5; opb = r_q[0]; ctl.op = ALU_MUL; dst = R2; end
          5'd3: begin opa = r_q[1]; opb = r_q[2]; ctl.op = ALU_SUB; dst = R1; end
          5'd4: begin opa = r_q[1]; opb = 32'd16384; ctl.sh = 5'd15; dst = R1; end
          5'd5: begin opa = r_q[0]; opb = h6; ctl.op = ALU_MUL; ctl.sh = 5'd10; dst = R2; end
          5'd6: begin opa = r_q[0]; opb = h3; ctl.op = ALU_MUL; ctl.sh = 5'd11; dst = R3; end
          5'd7: begin opa = r_q[3]; opb = 32'd32768; dst = R3; end
          5'd8: begin opa = r_q[2]; opb = r_q[3]; ctl.op = ALU_MUL; ctl.sh = 5'd10; dst = R2; end
          5'd9: begin opa = r_q[2]; opb = 32'd2097152; dst = R2; end
          5'd10: begin opa = r_q[2]; opb = h2; ctl.op = ALU_MUL; dst = R2; end
          5'd11: begin opa = r_q[2]; opb = 32'd8192; ctl.sh = 5'd14; dst = R2; end
          5'd12: begin opa = r_q[1]; opb = r_q[2]; ctl.op = ALU_MUL; dst = R4; end
          5'd13: begin opa = r_q[4]; ctl.sh = 5'd15; dst = R3; end
          5'd14: begin opa = r_q[3]; opb = r_q[3]; ctl.op = ALU_MUL; ctl.sh = 5'd7; dst = R3; end
          5'd15: begin opa = r_q[3]; opb = h1; ctl.op = ALU_MUL; ctl.sh = 5'd4; dst = R3; end
          5'd16: begin opa = r_q[4]; opb = r_q[3]; ctl.op = ALU_SUB; dst = R4; end
          default: wr = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  ecomp_alu u_alu (
    .ctl_i (ctl),
    .a_i   (opa),
    .b_i   (opb),
    .y_o   (alu_y)
  );

  // Divider for the pressure step; the dividend is doubled first when it fits.
  logic        div_start, div_done;
  logic [31:0] div_quo, div_dvd;

  assign div_start = (state_q == ST_DIVGO) && (r_q[3] != '0);
  assign div_dvd   = r_q[4][31] ? r_q[4] : {r_q[4][30:0], 1'b0};

  ecomp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (r_q[3]),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // Temperature scaling with saturation.
  logic signed [34:0] f35, t35;
  logic signed [26:0] tsh;
  logic signed [15:0] tsat;

  always_comb begin
    f35 = 35'(signed'(fine_q));
    t35 = (f35 <<< 2) + f35 + 35'sd128;
    tsh = 27'(t35 >>> 8);
    if (tsh > 27'sd32767) begin
      tsat = 16'sh7fff;
    end else if (tsh < -27'sd32768) begin
      tsat = -16'sh8000;
    end else begin
      tsat = tsh[15:0];
    end
  end

  // Humidity clamp and final shift.
  logic [16:0] hclamp;

  always_comb begin
    if (r_q[4][31]) begin
      hclamp = '0;
    end else if (r_q[4] > 32'd419430400) begin
      hclamp = 17'd102400;
    end else begin
      hclamp = r_q[4][28:12];
    end
  end

  logic tskip, pskip, hskip;
  assign tskip = (traw_q == RAW_SKIP_24);
  assign pskip = (praw_q == RAW_SKIP_24);
  assign hskip = (hraw_q == RAW_SKIP_16);

  // Sequencer: state, step, fine temperature and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      fine_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && out_o.ready && state_q != ST_DONE) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            state_q <= ST_TEMP;
            step_q  <= '0;
          end
        end
        ST_TEMP: begin
          if (step_q == '0 && tskip) begin
            state_q <= ST_PRESS;
          end else begin
            if (wr_fine) begin
              fine_q <= alu_y;
            end
            if (step_q == TEMP_LAST) begin
              state_q <= ST_PRESS;
              step_q  <= '0;
            end else begin
              step_q <= step_q + 5'd1;
            end
          end
        end
        ST_PRESS: begin
          if (step_q == '0 && pskip) begin
            state_q <= ST_HUM;
          end else if (step_q == PRESS_LAST) begin
            state_q <= ST_DIVGO;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_DIVGO: begin
          state_q <= (r_q[3] == '0) ? ST_HUM : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          if (step_q == POST_LAST) begin
            state_q <= ST_HUM;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_HUM: begin
          if (step_q == '0 && hskip) begin
            state_q <= ST_DONE;
          end else if (step_q == HUM_LAST) begin
            state_q <= ST_DONE;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: raw readings, scratch registers and results.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      traw_q <= in_i.temp_raw;
      praw_q <= in_i.press_raw;
      hraw_q <= in_i.hum_raw;
    end
    if (wr) begin
      r_q[dst] <= alu_y;
    end
    if (state_q == ST_DIV && div_done) begin
      r_q[4] <= r_q[4][31] ? {div_quo[30:0], 1'b0} : div_quo;
    end
    case (state_q)
      ST_TEMP: begin
        if (step_q == '0 && tskip) begin
          temp_res_q <= '0;
        end else if (step_q == TEMP_LAST) begin
          temp_res_q <= tsat;
        end
      end
      ST_PRESS: begin
        if (step_q == '0 && pskip) begin
          press_res_q <= '0;
        end
      end
      ST_DIVGO: begin
        if (r_q[3] == '0) begin
          press_res_q <= '0;
        end
      end
      ST_POST: begin
        if (step_q == POST_LAST) begin
          press_res_q <= r_q[5];
        end
      end
      ST_HUM: begin
        if (step_q == '0 && hskip) begin
          hum_res_q <= '0;
        end else if (step_q == HUM_LAST) begin
          hum_res_q <= hclamp;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_temp_q  <= temp_res_q;
          out_press_q <= press_res_q;
          out_hum_q   <= hum_res_q;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.temperature = out_temp_q;
  assign out_o.pressure    = out_press_q;
  assign out_o.humidity    = out_hum_q;

endmodule

// ===== tb/tb.sv =====
// Testbench of the environment sensor compensation block with its own integer predictor.
`timescale 1ns / 100ps

module tb;
  import ecomp_pkg::*;

  // Index that maps to no register; a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd5;
  localparam int unsigned        StallLimit = 5000;
  localparam int unsigned        LongHold   = 400;
  localparam int unsigned        DrainWait  = 200;

  typedef struct {
    logic signed [15:0] temperature;
    logic        [31:0] pressure;
    logic        [16:0] humidity;
  } comp_reading_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  ecomp_in_if  raw_bus ();
  ecomp_out_if comp_bus ();

  environment_sensor_compensation i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (raw_bus),
    .out_o      (comp_bus)
  );

  // Predictor copy of the calibration registers and the fine temperature.
  logic [47:0] cal_temp;
  logic [63:0] cal_plow;
  logic [63:0] cal_phigh;
  logic [15:0] cal_pnine;
  logic [63:0] cal_hum;
  int          fine_temp;

  comp_reading_t expected_readings[$];
  bit            failed;
  bit            idle_en;
  bit            hold_req;
  int unsigned   quiet_cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Temperature formula; updates the fine temperature.
  function automatic logic signed [15:0] comp_temperature(logic [23:0] raw);
    int          adc, t1, t2, t3, v1, v2, d;
    longint      t;
    shortint     s2, s3;
    adc = int'(raw >> 4);
    t1  = int'(cal_temp[15:0]);
    s2  = cal_temp[31:16];
    s3  = cal_temp[47:32];
    t2  = s2;
    t3  = s3;
    v1  = (((adc >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d   = (adc >>> 4) - t1;
    v2  = (((d * d) >>> 12) * t3) >>> 14;
    fine_temp = v1 + v2;
    t = (longint'(fine_temp) * 5 + 128) >>> 8;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  // Pressure formula with the split unsigned division.
  function automatic logic [31:0] comp_pressure(logic [23:0] raw);
    int          adc, p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, q;
    shortint     s;
    logic [31:0] p, dv;
    adc = int'(raw >> 4);
    p1  = int'(cal_plow[15:0]);
    s = cal_plow[31:16];   p2 = s;
    s = cal_plow[47:32];   p3 = s;
    s = cal_plow[63:48];   p4 = s;
    s = cal_phigh[15:0];   p5 = s;
    s = cal_phigh[31:16];  p6 = s;
    s = cal_phigh[47:32];  p7 = s;
    s = cal_phigh[63:48];  p8 = s;
    s = cal_pnine;         p9 = s;
    a = (fine_temp >>> 1) - 64000;
    q = a >>> 2;
    b = ((q * q) >>> 11) * p6;
    b = b + ((a * p5) <<< 1);
    b = (b >>> 2) + (p4 <<< 16);
    a = (((p3 * ((q * q) >>> 13)) >>> 3) + ((p2 * a) >>> 1)) >>> 18;
    a = ((32768 + a) * p1) >>> 15;
    if (a == 0) return 32'd0;
    dv = a;
    p  = 32'(1048576 - adc) - 32'(b >>> 12);
    p  = p * 32'd3125;
    if (p < 32'h8000_0000) p = (p << 1) / dv;
    else p = (p / dv) * 32'd2;
    a = (p9 * int'(((p >> 3) * (p >> 3)) >> 13)) >>> 12;
    b = (int'(p >> 2) * p8) >>> 13;
    return 32'(int'(p) + ((a + b + p7) >>> 4));
  endfunction

  // Humidity formula with the clamp before the final shift.
  function automatic logic [16:0] comp_humidity(logic [15:0] raw);
    int                 h1, h2, h3, h4, h5, h6, v, x, y, z;
    shortint            s2;
    logic signed [11:0] s12;
    byte                s8;
    h1  = int'(cal_hum[7:0]);
    s2  = cal_hum[23:8];   h2 = s2;
    h3  = int'(cal_hum[31:24]);
    s12 = cal_hum[43:32];  h4 = s12;
    s12 = cal_hum[55:44];  h5 = s12;
    s8  = cal_hum[63:56];  h6 = s8;
    v = fine_temp - 76800;
    x = ((int'(raw) <<< 14) - (h4 <<< 20)) - h5 * v;
    x = (x + 16384) >>> 15;
    y = (v * h6) >>> 10;
    z = ((v * h3) >>> 11) + 32768;
    y = ((y * z) >>> 10) + 2097152;
    y = ((y * h2) + 8192) >>> 14;
    v = x * y;
    z = v >>> 15;
    v = v - ((((z * z) >>> 7) * h1) >>> 4);
    if (v < 0) v = 0;
    if (v > 419430400) v = 419430400;
    return 17'(v >> 12);
  endfunction

  // Expected result of one raw beat; updates the predictor state in order.
  function automatic comp_reading_t compensate(logic [23:0] t, logic [23:0] p,
                                               logic [15:0] h);
    comp_reading_t r;
    r.temperature = (t == RAW_SKIP_24) ? 16'sd0 : comp_temperature(t);
    r.pressure    = (p == RAW_SKIP_24) ? 32'd0 : comp_pressure(p);
    r.humidity    = (h == RAW_SKIP_16) ? 17'd0 : comp_humidity(h);
    return r;
  endfunction

  // Withdraws the raw beat, then waits until every expected result is out and the block
  // has settled.
  task automatic wait_drained();
    raw_bus.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Writes one calibration register while the block is idle.
  task automatic write_cal(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_TEMP:  cal_temp  = data[47:0];
      CFG_PLOW:  cal_plow  = data;
      CFG_PHIGH: cal_phigh = data;
      CFG_PNINE: cal_pnine = data[15:0];
      CFG_HUM:   cal_hum   = data;
      default: ;
    endcase
  endtask

  task automatic write_all_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                               logic [63:0] p9, logic [63:0] hc);
    write_cal(CFG_TEMP, tc);
    write_cal(CFG_PLOW, pl);
    write_cal(CFG_PHIGH, ph);
    write_cal(CFG_PNINE, p9);
    write_cal(CFG_HUM, hc);
  endtask

  // Typical calibration of a healthy sensor.
  task automatic write_typical_cal();
    write_all_cal({16'(-1000), 16'd26435, 16'd27504},
                  {16'd2855, 16'd3024, 16'(-10685), 16'd36477},
                  {16'(-14600), 16'd15500, 16'(-7), 16'd140},
                  64'd6000,
                  {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
  endtask

  // Sends one raw beat and records its expected result when it is accepted.
  task automatic send_raw(logic [23:0] t, logic [23:0] p, logic [15:0] h);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      raw_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    raw_bus.valid     <= 1'b1;
    raw_bus.temp_raw  <= t;
    raw_bus.press_raw <= p;
    raw_bus.hum_raw   <= h;
    do @(posedge clk_i); while (!raw_bus.ready);
    expected_readings.push_back(compensate(t, p, h));
  endtask

  task automatic stop_sending();
    raw_bus.valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_temp_raw();
    case ($urandom_range(0, 9))
      0:       return RAW_SKIP_24;
      1, 2:    return 24'($urandom);
      default: return {20'($urandom_range(380000, 620000)), 4'($urandom)};
    endcase
  endfunction

  function automatic logic [23:0] pick_press_raw();
    case ($urandom_range(0, 9))
      0:       return RAW_SKIP_24;
      1, 2:    return 24'($urandom);
      default: return {20'($urandom_range(200000, 480000)), 4'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] pick_hum_raw();
    case ($urandom_range(0, 9))
      0:       return RAW_SKIP_16;
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(18000, 42000));
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    repeat (n) send_raw(pick_temp_raw(), pick_press_raw(), pick_hum_raw());
  endtask

  // Calibration at reset is all zero: pressure divisor is zero.
  task automatic test_reset_cal();
    send_raw(24'h7EEE00, 24'h65A000, 16'h6A00);
    send_raw(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_raw(24'h000000, 24'h000000, 16'h0000);
  endtask

  // Field extremes and skipped channels with typical calibration.
  task automatic test_directed();
    write_typical_cal();
    write_cal(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_raw(24'h7EEE00, 24'h65A000, 16'h6A00);
    send_raw(24'h000000, 24'h000000, 16'h0000);
    send_raw(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_raw(RAW_SKIP_24, 24'h65A000, 16'h6A00);
    send_raw(24'h7EEE00, RAW_SKIP_24, 16'h6A00);
    send_raw(24'h7EEE00, 24'h65A000, RAW_SKIP_16);
    send_raw(RAW_SKIP_24, RAW_SKIP_24, RAW_SKIP_16);
    send_raw(24'h7FFFFF, 24'h800001, 16'h7FFF);
    send_raw(24'h800001, 24'h7FFFFF, 16'h8001);
    send_raw(24'h00000F, 24'h00000F, 16'h0001);
  endtask

  // Extreme calibration words, saturation of temperature and clamping of humidity.
  task automatic test_extreme_cal();
    write_all_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF);
    send_raw(24'hFFFFFF, 24'h000000, 16'hFFFF);
    send_raw(24'h000000, 24'hFFFFFF, 16'h0000);
    write_all_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                  {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF,
                  {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
    send_raw(24'hFFFFFF, 24'h400000, 16'hFFFF);
    send_raw(24'h000000, 24'h400000, 16'h0000);
    write_all_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                  {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000,
                  {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00});
    send_raw(24'hFFFFFF, 24'h400000, 16'hFFFF);
    send_raw(24'h123450, 24'h000000, 16'h4000);
  endtask

  // Random readings over several calibration sets, typical and random.
  task automatic test_random_cal();
    repeat (6) begin
      if ($urandom_range(0, 1) == 0) begin
        write_typical_cal();
      end else begin
        write_all_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      64'($urandom), {$urandom, $urandom});
      end
      send_random(200);
    end
  endtask

  // The result side holds off for a long stretch while raw beats keep coming.
  task automatic test_backpressure();
    write_typical_cal();
    hold_req = 1'b1;
    send_random(150);
  endtask

  // The sender pauses until the block has delivered everything.
  task automatic test_drain_pause();
    send_random(100);
    stop_sending();
    while (expected_readings.size() != 0) @(posedge clk_i);
    send_random(100);
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_en = 1'b0;
    send_random(250);
  endtask

  // Result side: random stall bursts, and one long hold when requested.
  initial begin
    comp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        comp_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
        comp_bus.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        comp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        comp_bus.ready <= 1'b1;
      end else begin
        comp_bus.ready <= rst_ni;
      end
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin
    comp_reading_t exp_r;
    if (rst_ni && comp_bus.valid && comp_bus.ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result beat: temperature %0d pressure %0d humidity %0d",
               comp_bus.temperature, comp_bus.pressure, comp_bus.humidity);
        failed = 1'b1;
      end else begin
        exp_r = expected_readings.pop_front();
        if (comp_bus.temperature !== exp_r.temperature) begin
          $error("temperature: expected %0d, actual %0d", exp_r.temperature,
                 comp_bus.temperature);
          failed = 1'b1;
        end
        if (comp_bus.pressure !== exp_r.pressure) begin
          $error("pressure: expected %0d, actual %0d", exp_r.pressure, comp_bus.pressure);
          failed = 1'b1;
        end
        if (comp_bus.humidity !== exp_r.humidity) begin
          $error("humidity: expected %0d, actual %0d", exp_r.humidity, comp_bus.humidity);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((raw_bus.valid && raw_bus.ready) || (comp_bus.valid && comp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    raw_bus.valid     = 1'b0;
    raw_bus.temp_raw  = '0;
    raw_bus.press_raw = '0;
    raw_bus.hum_raw   = '0;
    cal_temp          = '0;
    cal_plow          = '0;
    cal_phigh         = '0;
    cal_pnine         = '0;
    cal_hum           = '0;
    fine_temp         = 0;
    failed            = 1'b0;
    idle_en           = 1'b1;
    hold_req          = 1'b0;
    quiet_cycles      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_cal();
    test_directed();
    test_extreme_cal();
    test_random_cal();
    test_backpressure();
    test_drain_pause();
    test_full_rate();

    wait_drained();
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ecomp_pkg.sv
sv/ecomp_if.sv
sv/ecomp_alu.sv
sv/ecomp_div.sv
sv/environment_sensor_compensation.sv
tb/tb.sv
